/* hw/rtl/bsds_pkg.sv */
// ----------------------------------------------------------------------------
// bsds_pkg
// Shared constants and beat types for the bilinear dot splat pipeline.
// ----------------------------------------------------------------------------
package bsds_pkg;

	localparam int FRAC_W   = 4;   // fractional bits of a position
	localparam int FRAC_ONE = 16;  // one whole cell in position units
	localparam int CH_W     = 8;   // colour channel width
	localparam int WGT_W    = 9;   // bilinear weight, 0..256
	localparam int LED_W    = 6;   // pixel index width
	localparam int NCORNER  = 4;   // TL, TR, BL, BR

	typedef logic [CH_W-1:0] chan_t;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} rgb_t;

	// All four neighbor cells of one dot, bit k of mask marks a write
	typedef struct packed {
		logic [NCORNER-1:0]             mask;
		logic [NCORNER-1:0][LED_W-1:0]  idx;
		logic [NCORNER-1:0][WGT_W-1:0]  wgt;
		rgb_t                           rgb;
	} corner_set_t;

	// One pixel write before channel scaling
	typedef struct packed {
		logic [LED_W-1:0]  idx;
		logic [WGT_W-1:0]  wgt;
		logic              last;
		rgb_t              rgb;
	} pix_beat_t;

endpackage

/* hw/rtl/bsds_serial.sv */
// ----------------------------------------------------------------------------
// bsds_serial
// Holds a dot's corner set, sends live corners TL first, one beat per cycle
// if beat_ready is high; takes the next set in the cycle its last corner goes.
// ----------------------------------------------------------------------------
module bsds_serial
	import bsds_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         set_valid,
	output logic         set_ready,
	input  corner_set_t  set_data,
	output logic         beat_valid,
	input  logic         beat_ready,
	output pix_beat_t    beat
);

	logic                valid_q;
	logic [NCORNER-1:0]  mask_q;
	corner_set_t         set_q;

	logic [NCORNER-1:0]  pick;
	logic [NCORNER-1:0]  rest;
	logic                last;
	logic                fire;

	// lowest pending corner wins
	always_comb begin
		pick = mask_q & NCORNER'(-mask_q);
		rest = mask_q & ~pick;
		last = (rest == '0);
	end

	assign beat_valid = valid_q;
	assign fire       = valid_q && beat_ready;
	assign set_ready  = !valid_q || (fire && last);

	// one-hot select of the chosen corner
	always_comb begin
		beat.idx  = '0;
		beat.wgt  = '0;
		beat.last = last;
		beat.rgb  = set_q.rgb;
		for (int k = 0; k < NCORNER; k++) begin
			if (pick[k]) begin
				beat.idx = beat.idx | set_q.idx[k];
				beat.wgt = beat.wgt | set_q.wgt[k];
			end
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			mask_q  <= '0;
		end else if (set_valid && set_ready) begin
			valid_q <= 1'b1;
			mask_q  <= set_data.mask;
		end else if (fire) begin
			valid_q <= !last;
			mask_q  <= rest;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (set_valid && set_ready) begin
			set_q <= set_data;
		end
	end

endmodule

/* hw/rtl/bilinear_subpixel_dot_splat.sv */
// ----------------------------------------------------------------------------
// bilinear_subpixel_dot_splat
// Clamps a Q4 dot position to the board, forms bilinear weights for the four
// neighbor cells and emits one scaled GRB pixel write per live cell.
// ----------------------------------------------------------------------------
// Path: a dot passes the stage 1, stage 2, serializer, stage 3 and stage 4
//   registers before its first write leaves; the rest follow one per cycle
//   while out_stall is low. A new dot can enter before the last one is out;
//   the corner serializer feeding the single write channel sets the pace.
// Reset: arst_n clears all valid bits; the pipeline starts empty.
// ----------------------------------------------------------------------------
module bilinear_subpixel_dot_splat
	import bsds_pkg::*;
#(
	parameter int BOARD_WIDTH  = 8,
	parameter int BOARD_HEIGHT = 8
)(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] pos_x_q4,
	input  logic signed [15:0] pos_y_q4,
	input  logic [CH_W-1:0]    red_in,
	input  logic [CH_W-1:0]    green_in,
	input  logic [CH_W-1:0]    blue_in,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [LED_W-1:0]   led_index,
	output logic [CH_W-1:0]    green_out,
	output logic [CH_W-1:0]    red_out,
	output logic [CH_W-1:0]    blue_out,
	output logic               last_write
);

	localparam int CXW   = $clog2(BOARD_WIDTH);
	localparam int CYW   = $clog2(BOARD_HEIGHT);
	localparam int PXW   = CXW + FRAC_W;
	localparam int PYW   = CYW + FRAC_W;
	localparam int MAX_X = (BOARD_WIDTH - 1) * FRAC_ONE;
	localparam int MAX_Y = (BOARD_HEIGHT - 1) * FRAC_ONE;
	localparam int IXW   = CXW + CYW + 2;
	localparam int PRW   = CH_W + WGT_W;

	// stage 1: clamped position
	logic            v_s1;
	logic [PXW-1:0]  px_s1;
	logic [PYW-1:0]  py_s1;
	rgb_t            rgb_s1;

	// stage 2: corner set
	logic            v_s2;
	corner_set_t     set_s2;

	// stage 3: one serialized write
	logic            v_s3;
	pix_beat_t       beat_s3;

	// stage 4: output register
	logic            v_s4;
	logic [LED_W-1:0] idx_s4;
	chan_t           red_s4;
	chan_t           green_s4;
	chan_t           blue_s4;
	logic            last_s4;

	logic            rdy_s1;
	logic            rdy_s2;
	logic            rdy_s3;
	logic            rdy_s4;
	logic            ser_ready;
	logic            ser_valid;
	pix_beat_t       ser_beat;

	logic [PXW-1:0]  px_c;
	logic [PYW-1:0]  py_c;
	corner_set_t     set_c;
	chan_t           red_c;
	chan_t           green_c;
	chan_t           blue_c;

	// stall chain, back to front
	assign rdy_s4   = !v_s4 || !out_stall;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || ser_ready;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	// saturate each axis to 0 .. (dim - 1) * 16
	always_comb begin
		if (pos_x_q4[15]) begin
			px_c = '0;
		end else if ($unsigned(pos_x_q4) > 16'(MAX_X)) begin
			px_c = PXW'(MAX_X);
		end else begin
			px_c = pos_x_q4[PXW-1:0];
		end
		if (pos_y_q4[15]) begin
			py_c = '0;
		end else if ($unsigned(pos_y_q4) > 16'(MAX_Y)) begin
			py_c = PYW'(MAX_Y);
		end else begin
			py_c = pos_y_q4[PYW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy_s1) begin
			px_s1        <= px_c;
			py_s1        <= py_c;
			rgb_s1.red   <= red_in;
			rgb_s1.green <= green_in;
			rgb_s1.blue  <= blue_in;
		end
	end

	// weights, cell indexes and live mask for the four corners
	always_comb begin
		logic [CXW-1:0]    cx;
		logic [CYW-1:0]    cy;
		logic [FRAC_W-1:0] fx;
		logic [FRAC_W-1:0] fy;
		logic [FRAC_W:0]   wx [2];
		logic [FRAC_W:0]   wy [2];
		logic [CXW:0]      col;
		logic [CYW:0]      row;
		logic [IXW-1:0]    ix;
		logic [WGT_W-1:0]  w;

		cx    = px_s1[PXW-1:FRAC_W];
		cy    = py_s1[PYW-1:FRAC_W];
		fx    = px_s1[FRAC_W-1:0];
		fy    = py_s1[FRAC_W-1:0];
		wx[0] = (FRAC_W+1)'(FRAC_ONE) - {1'b0, fx};
		wx[1] = {1'b0, fx};
		wy[0] = (FRAC_W+1)'(FRAC_ONE) - {1'b0, fy};
		wy[1] = {1'b0, fy};
		set_c.rgb = rgb_s1;
		for (int k = 0; k < NCORNER; k++) begin
			col = {1'b0, cx} + (CXW+1)'(k % 2);
			row = {1'b0, cy} + (CYW+1)'(k / 2);
			w   = WGT_W'(wx[k % 2]) * WGT_W'(wy[k / 2]);
			ix  = IXW'(row) * IXW'(BOARD_WIDTH) + IXW'(col);
			set_c.idx[k]  = LED_W'(ix);
			set_c.wgt[k]  = w;
			set_c.mask[k] = (w != '0) && (col < (CXW+1)'(BOARD_WIDTH))
				&& (row < (CYW+1)'(BOARD_HEIGHT));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && rdy_s2) begin
			set_s2 <= set_c;
		end
	end

	// one corner per cycle onto the write channel while stage 3 takes it
	bsds_serial u_serial (
		.clk        (clk),
		.arst_n     (arst_n),
		.set_valid  (v_s2),
		.set_ready  (ser_ready),
		.set_data   (set_s2),
		.beat_valid (ser_valid),
		.beat_ready (rdy_s3),
		.beat       (ser_beat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= ser_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_valid && rdy_s3) begin
			beat_s3 <= ser_beat;
		end
	end

	// channel * weight >> 8; a full weight of 256 passes the channel
	always_comb begin
		red_c   = CH_W'((PRW'(beat_s3.rgb.red)   * PRW'(beat_s3.wgt)) >> 8);
		green_c = CH_W'((PRW'(beat_s3.rgb.green) * PRW'(beat_s3.wgt)) >> 8);
		blue_c  = CH_W'((PRW'(beat_s3.rgb.blue)  * PRW'(beat_s3.wgt)) >> 8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && rdy_s4) begin
			idx_s4   <= beat_s3.idx;
			red_s4   <= red_c;
			green_s4 <= green_c;
			blue_s4  <= blue_c;
			last_s4  <= beat_s3.last;
		end
	end

	assign out_valid  = v_s4;
	assign led_index  = idx_s4;
	assign red_out    = red_s4;
	assign green_out  = green_s4;
	assign blue_out   = blue_s4;
	assign last_write = last_s4;

endmodule

/* hw/rtl/bsds_checker.sv */
// ----------------------------------------------------------------------------
// bsds_checker
// Port-level checks on the splat write channel, bound to the top level.
// ----------------------------------------------------------------------------
module bsds_checker
	import bsds_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic [LED_W-1:0] led_index,
	input  logic [CH_W-1:0]  green_out,
	input  logic [CH_W-1:0]  red_out,
	input  logic [CH_W-1:0]  blue_out,
	input  logic             last_write
);

	// a stalled write beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(led_index)
			&& $stable(red_out) && $stable(green_out) && $stable(blue_out)
			&& $stable(last_write))
		else $error("stalled write beat changed");

	// writes of one dot leave back to back: no gap inside a run
	a_run_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_write |=> out_valid)
		else $error("gap inside a dot's write run");

	// nothing leaves while in reset, once the first reset edge has cleared it
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !out_valid)
		else $error("write beat during reset");

	// a run of one dot that leaves unstalled holds at most four writes
	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_write
			##1 out_valid && !out_stall && !last_write
			##1 out_valid && !out_stall && !last_write
			|=> out_valid && last_write)
		else $error("dot run longer than four writes");

endmodule

bind bilinear_subpixel_dot_splat bsds_checker u_bsds_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.led_index  (led_index),
	.green_out  (green_out),
	.red_out    (red_out),
	.blue_out   (blue_out),
	.last_write (last_write)
);

/* sim/bilinear_subpixel_dot_splat_tb.sv */
// ----------------------------------------------------------------------------
// bilinear_subpixel_dot_splat_tb
// Drives Q4 dot positions and colors into the splat block and checks every
// pixel write beat against a bilinear predictor kept in the bench. The run
// is a short directed set followed by random dots under three mixes of
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module bilinear_subpixel_dot_splat_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bsds_pkg::*;

	localparam int BOARD_W    = 8;
	localparam int BOARD_H    = 8;
	localparam int RAND_DOTS  = 100;   // per idling phase
	localparam int DRAIN_WAIT = 20;    // cycles after the last write

	// One dot waiting to be driven
	typedef struct {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [CH_W-1:0]    r;
		logic [CH_W-1:0]    g;
		logic [CH_W-1:0]    b;
		bit                 drain_first;
	} dot_t;

	// One predicted pixel write
	typedef struct {
		logic [LED_W-1:0] idx;
		logic [CH_W-1:0]  g;
		logic [CH_W-1:0]  r;
		logic [CH_W-1:0]  b;
		logic             last;
	} pixel_write_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [15:0] pos_x_q4 = '0;
	logic signed [15:0] pos_y_q4 = '0;
	logic [CH_W-1:0]    red_in = '0;
	logic [CH_W-1:0]    green_in = '0;
	logic [CH_W-1:0]    blue_in = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [LED_W-1:0]   led_index;
	logic [CH_W-1:0]    green_out;
	logic [CH_W-1:0]    red_out;
	logic [CH_W-1:0]    blue_out;
	logic               last_write;

	dot_t         dot_q[$];
	pixel_write_t pixel_q[$];

	int unsigned sender_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned dots_taken = 0;
	int unsigned writes_seen = 0;
	int unsigned clamped_dots = 0;
	int unsigned quad_dots = 0;
	int unsigned mismatches = 0;

	bilinear_subpixel_dot_splat #(
		.BOARD_WIDTH  (BOARD_W),
		.BOARD_HEIGHT (BOARD_H)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.pos_x_q4   (pos_x_q4),
		.pos_y_q4   (pos_y_q4),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.led_index  (led_index),
		.green_out  (green_out),
		.red_out    (red_out),
		.blue_out   (blue_out),
		.last_write (last_write)
	);

	always #5 clk = ~clk;

	// Saturate a Q4 coordinate to 0 .. (dim-1) cells
	function automatic int clamp_q4(logic signed [15:0] v, int dim);
		int s;
		int top;
		s = v;
		top = (dim - 1) * FRAC_ONE;
		if (s < 0)
			return 0;
		if (s > top)
			return top;
		return s;
	endfunction

	// Expected writes of one dot, TL, TR, BL, BR, zero weights and off-board cells dropped
	task automatic predict_splat(logic signed [15:0] x, logic signed [15:0] y,
			logic [CH_W-1:0] r, logic [CH_W-1:0] g, logic [CH_W-1:0] b);
		int px;
		int py;
		int wx[2];
		int wy[2];
		int col;
		int row;
		int wgt;
		pixel_write_t wr;
		pixel_write_t dot_writes[$];
		px = clamp_q4(x, BOARD_W);
		py = clamp_q4(y, BOARD_H);
		if (px != x || py != y)
			clamped_dots++;
		wx[1] = px % FRAC_ONE;
		wx[0] = FRAC_ONE - wx[1];
		wy[1] = py % FRAC_ONE;
		wy[0] = FRAC_ONE - wy[1];
		for (int k = 0; k < NCORNER; k++) begin
			col = (px >> FRAC_W) + (k & 1);
			row = (py >> FRAC_W) + (k >> 1);
			wgt = wx[k & 1] * wy[k >> 1];
			if (wgt != 0 && col < BOARD_W && row < BOARD_H) begin
				wr.idx  = LED_W'(row * BOARD_W + col);
				wr.g    = CH_W'((int'(g) * wgt) >> 8);
				wr.r    = CH_W'((int'(r) * wgt) >> 8);
				wr.b    = CH_W'((int'(b) * wgt) >> 8);
				wr.last = 1'b0;
				dot_writes.push_back(wr);
			end
		end
		dot_writes[dot_writes.size() - 1].last = 1'b1;
		if (dot_writes.size() == NCORNER)
			quad_dots++;
		foreach (dot_writes[i])
			pixel_q.push_back(dot_writes[i]);
	endtask

	task automatic add_dot(int x, int y, int r, int g, int b, bit drain = 1'b0);
		dot_t d;
		d.x = 16'(x);
		d.y = 16'(y);
		d.r = CH_W'(r);
		d.g = CH_W'(g);
		d.b = CH_W'(b);
		d.drain_first = drain;
		dot_q.push_back(d);
	endtask

	// Mostly on or near the board; some fully random 16-bit positions
	function automatic int rand_coord(int dim);
		if ($urandom_range(9) < 7)
			return int'($urandom_range((dim - 1) * FRAC_ONE + 48)) - 24;
		return int'($urandom_range(16'hFFFF)) - 32768;
	endfunction

	function automatic int rand_chan();
		case ($urandom_range(9))
			0: return 0;
			1: return 255;
			default: return int'($urandom_range(255));
		endcase
	endfunction

	task automatic add_random_dots(int n);
		for (int i = 0; i < n; i++)
			add_dot(rand_coord(BOARD_W), rand_coord(BOARD_H), rand_chan(),
				rand_chan(), rand_chan(), i == n / 2);
	endtask

	task automatic wait_idle();
		while (dot_q.size() != 0 || in_valid || pixel_q.size() != 0)
			@(posedge clk);
	endtask

	// Driver: predicts on each accepted beat, then offers the next dot
	always @(posedge clk or negedge arst_n) begin : drive
		dot_t nxt;
		bit   load;
		if (!arst_n) begin
			in_valid <= 1'b0;
			pos_x_q4 <= '0;
			pos_y_q4 <= '0;
			red_in   <= '0;
			green_in <= '0;
			blue_in  <= '0;
		end else begin
			load = 1'b0;
			if (in_valid && !in_stall) begin
				predict_splat(pos_x_q4, pos_y_q4, red_in, green_in, blue_in);
				dots_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (dot_q.size() != 0 && $urandom_range(99) >= sender_idle_pct &&
						(!dot_q[0].drain_first || pixel_q.size() == 0)) begin
					nxt = dot_q.pop_front();
					load = 1'b1;
				end
				in_valid <= load;
				if (load) begin
					pos_x_q4 <= nxt.x;
					pos_y_q4 <= nxt.y;
					red_in   <= nxt.r;
					green_in <= nxt.g;
					blue_in  <= nxt.b;
				end
			end
		end
	end

	// Monitor: checks each write beat against the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watch
		pixel_write_t exp_wr;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				writes_seen++;
				if (pixel_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected write: idx %0d g %0d r %0d b %0d last %0b",
							led_index, green_out, red_out, blue_out, last_write);
				end else begin
					exp_wr = pixel_q.pop_front();
					if (led_index !== exp_wr.idx || green_out !== exp_wr.g ||
							red_out !== exp_wr.r || blue_out !== exp_wr.b ||
							last_write !== exp_wr.last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("write mismatch: expected idx %0d g %0d r %0d b %0d last %0b, ",
								exp_wr.idx, exp_wr.g, exp_wr.r, exp_wr.b, exp_wr.last);
							$display("got idx %0d g %0d r %0d b %0d last %0b",
								led_index, green_out, red_out, blue_out, last_write);
						end
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Stimulus and end of run
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed dots: grid points, fractions, edges, saturation, colors
		sender_idle_pct = 12;
		recv_idle_pct = 79;
		add_dot(0, 0, 255, 255, 255);                 // full weight, one write
		add_dot(112, 112, 1, 2, 3);                   // bottom-right cell
		add_dot(-32768, -32768, 200, 100, 50);        // clamp low on both axes
		add_dot(32767, 32767, 10, 20, 30);            // clamp high on both axes
		add_dot(-1, 50, 255, 0, 128);                 // x just below board
		add_dot(113, 40, 77, 88, 99);                 // x just past right edge
		add_dot(56, 0, 255, 255, 255);                // x half cell, two writes
		add_dot(16, 40, 255, 255, 255);               // y fraction only
		add_dot(24, 40, 255, 255, 255, 1'b1);         // four equal weights
		add_dot(31, 47, 255, 255, 255);               // fractions of 15
		add_dot(17, 33, 255, 255, 255);               // fractions of 1
		add_dot(95, 81, 0, 0, 0);                     // black dot
		add_dot(111, 111, 255, 1, 128);               // corner fractions
		add_dot(8, -500, 123, 45, 67);                // y clamped, x split
		add_dot(-300, 119, 99, 199, 9);               // x low, y high
		add_dot(16'h7FFF, -16'sd1 * 20, 255, 255, 0); // right top corner
		add_random_dots(RAND_DOTS);
		wait_idle();

		sender_idle_pct = 79;
		recv_idle_pct = 12;
		add_random_dots(RAND_DOTS);
		wait_idle();

		sender_idle_pct = 0;
		recv_idle_pct = 0;
		add_random_dots(RAND_DOTS);
		wait_idle();

		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d dots (%0d clamped at an edge, %0d spread over four cells)",
			dots_taken, clamped_dots, quad_dots);
		$display("checked %0d pixel write beats, %0d mismatches", writes_seen, mismatches);
		if (mismatches == 0 && pixel_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#2ms;
		$display("timeout: %0d writes still expected", pixel_q.size());
		$display("status: fail");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/bsds_pkg.sv
hw/rtl/bsds_serial.sv
hw/rtl/bilinear_subpixel_dot_splat.sv
hw/rtl/bsds_checker.sv
sim/bilinear_subpixel_dot_splat_tb.sv
